/* design/hpa_pkg.sv */
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types and constants for the hsv pixel adjust pipeline.
// ----------------------------------------------------------------------------
package hpa_pkg;

  // fixed point formats: hue in 1/64 degree, s and v in q1.16
  localparam int FULL_DEG = 23040;
  localparam int SEXTANT  = 3840;
  localparam int ONE_Q16  = 65536;
  localparam int SEXT_K   = 251658240;

  // reciprocal constants, floor(x*m >> shift) equals floor(x/div) in range
  localparam logic [24:0] RECIP_100 = 25'd21474837;
  localparam logic [20:0] RECIP_15  = 21'd1118482;

  // configuration register indexes
  localparam int          CFG_IDX_W = 2;
  localparam logic [1:0]  CFG_HUE   = 2'd0;
  localparam logic [1:0]  CFG_SAT   = 2'd1;
  localparam logic [1:0]  CFG_VAL   = 2'd2;

  // which channel holds the maximum
  localparam logic [1:0]  BASE_RED  = 2'd0;
  localparam logic [1:0]  BASE_GRN  = 2'd1;
  localparam logic [1:0]  BASE_BLU  = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    logic signed [8:0] hue_offset;
    logic signed [7:0] saturation_percent;
    logic signed [7:0] value_percent;
  } cfg_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
    logic [7:0]  alpha;
  } hsv_t;

endpackage

/* design/hpa_div.sv */
// ----------------------------------------------------------------------------
// hpa_div
// Pipelined restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module hpa_div #(
  parameter int QW  = 12,
  parameter int DW  = 8,
  parameter int NST = 5
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] dvs_i,
  output logic [QW-1:0] quo_o
);
  localparam int IPS = (QW + NST - 1) / NST;
  localparam int AW  = DW + QW;

  logic [AW-1:0] acc_r   [NST];
  logic [AW-1:0] acc_nxt [NST];
  logic [DW-1:0] dvs_r   [NST];
  logic [DW-1:0] dvs_nxt [NST];

  // shift-subtract iterations of every stage
  always_comb begin
    logic [AW-1:0] a;
    logic [DW:0]   t;
    logic [DW-1:0] dv;
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        a  = {rem_i, low_i};
        dv = dvs_i;
      end else begin
        a  = acc_r[(k == 0) ? 0 : k - 1];
        dv = dvs_r[(k == 0) ? 0 : k - 1];
      end
      t = '0;
      for (int j = 0; j < IPS; j++) begin
        if (k * IPS + j < QW) begin
          t = {a[AW-1:QW], a[QW-1]};
          if (t >= {1'b0, dv}) begin
            t = t - {1'b0, dv};
            a = {t[DW-1:0], a[QW-2:0], 1'b1};
          end else begin
            a = {t[DW-1:0], a[QW-2:0], 1'b0};
          end
        end
      end
      acc_nxt[k] = a;
      dvs_nxt[k] = dv;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      dvs_r <= dvs_nxt;
    end
  end

  assign quo_o = acc_r[NST-1][QW-1:0];

endmodule

/* design/hpa_hsv_front.sv */
// ----------------------------------------------------------------------------
// hpa_hsv_front
// RGB to HSV: max/min, two pipelined divides, hue offset and wrap.
// ----------------------------------------------------------------------------
module hpa_hsv_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           vld_i,
  input  hpa_pkg::pix_in_t pix_i,
  input  hpa_pkg::cfg_t  cfg_i,
  output logic           vld_o,
  output hpa_pkg::hsv_t  hsv_o
);
  import hpa_pkg::*;

  localparam int NST = 5;

  typedef struct packed {
    logic [16:0] val;
    logic [1:0]  base;
    logic        neg;
    logic        dz;
    logic [7:0]  alpha;
  } side_t;

  // input register
  logic    vld0_r;
  pix_in_t pix0_r;

  // stage a
  logic        vlda_r, vlda_nxt;
  side_t       sda_r, sda_nxt;
  logic [19:0] hnum_r, hnum_nxt;
  logic [7:0]  d_r, d_nxt;
  logic [7:0]  mx_r, mx_nxt;

  // sideband alongside the dividers
  logic  vlds_r [NST];
  side_t sds_r  [NST];

  logic [11:0] quo_h;
  logic [16:0] quo_s;

  // output stage
  logic vldo_r;
  hsv_t hsv_r, hsv_nxt;

  // max, min, value and divide operands
  always_comb begin
    logic [7:0] r, g, b, mn;
    logic signed [8:0] diff;
    logic [7:0] mag;
    r = pix0_r.red_in;
    g = pix0_r.green_in;
    b = pix0_r.blue_in;
    mx_nxt = r;
    mn     = r;
    if (g > mx_nxt) mx_nxt = g;
    if (b > mx_nxt) mx_nxt = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d_nxt = mx_nxt - mn;
    if (r == mx_nxt) begin
      sda_nxt.base = BASE_RED;
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == mx_nxt) begin
      sda_nxt.base = BASE_GRN;
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sda_nxt.base = BASE_BLU;
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    sda_nxt.neg = diff[8];
    mag = diff[8] ? 8'(-diff) : diff[7:0];
    hnum_nxt = 20'(mag) * 20'(SEXTANT);
    sda_nxt.dz = (d_nxt == 8'd0);
    sda_nxt.val = {1'b0, mx_nxt, mx_nxt} + 17'(mx_nxt != 8'd0);
    sda_nxt.alpha = pix0_r.alpha_in;
    vlda_nxt = vld0_r;
  end

  // hue quotient: 3840*|diff| / d
  hpa_div #(.QW(12), .DW(8), .NST(NST)) u_div_hue (
    .clk   (clk),
    .adv   (adv),
    .rem_i (hnum_r[19:12]),
    .low_i (hnum_r[11:0]),
    .dvs_i (d_r),
    .quo_o (quo_h)
  );

  // saturation quotient: d*65536 / max
  hpa_div #(.QW(17), .DW(8), .NST(NST)) u_div_sat (
    .clk   (clk),
    .adv   (adv),
    .rem_i ({1'b0, d_r[7:1]}),
    .low_i ({d_r[0], 16'd0}),
    .dvs_i (mx_r),
    .quo_o (quo_s)
  );

  // hue from sector base, offset and wrap
  always_comb begin
    side_t sd;
    logic signed [16:0] base_v, hb, hs, off;
    sd = sds_r[NST-1];
    case (sd.base)
      BASE_GRN: base_v = 17'sd7680;
      BASE_BLU: base_v = 17'sd15360;
      default:  base_v = 17'sd0;
    endcase
    hb = sd.neg ? base_v - $signed({5'd0, quo_h}) : base_v + $signed({5'd0, quo_h});
    if (hb < 0) hb = hb + 17'(FULL_DEG);
    if (sd.dz) hb = '0;
    off = $signed({{2{cfg_i.hue_offset[8]}}, cfg_i.hue_offset, 6'd0});
    hs = hb + off;
    if (hs >= 17'(FULL_DEG)) hs = hs - 17'(FULL_DEG);
    if (hs < 0) hs = hs + 17'(FULL_DEG);
    hsv_nxt.hue   = hs[14:0];
    hsv_nxt.sat   = sd.dz ? 17'd0 : quo_s;
    hsv_nxt.val   = sd.val;
    hsv_nxt.alpha = sd.alpha;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vlda_r <= 1'b0;
      vldo_r <= 1'b0;
      for (int k = 0; k < NST; k++) vlds_r[k] <= 1'b0;
    end else if (adv) begin
      vld0_r <= vld_i;
      vlda_r <= vlda_nxt;
      vlds_r[0] <= vlda_r;
      for (int k = 1; k < NST; k++) vlds_r[k] <= vlds_r[k-1];
      vldo_r <= vlds_r[NST-1];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pix0_r <= pix_i;
      sda_r  <= sda_nxt;
      hnum_r <= hnum_nxt;
      d_r    <= d_nxt;
      mx_r   <= mx_nxt;
      sds_r[0] <= sda_r;
      for (int k = 1; k < NST; k++) sds_r[k] <= sds_r[k-1];
      hsv_r  <= hsv_nxt;
    end
  end

  assign vld_o = vldo_r;
  assign hsv_o = hsv_r;

  // hue always wrapped into one turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    vldo_r |-> (hsv_r.hue < 15'(FULL_DEG)))
    else $error("hue out of range");

  // saturation and value never above one
  a_sv_range: assert property (@(posedge clk) disable iff (!rst_n)
    vldo_r |-> (hsv_r.sat <= 17'(ONE_Q16) && hsv_r.val <= 17'(ONE_Q16)))
    else $error("saturation or value above one");

endmodule

/* design/hpa_rgb_back.sv */
// ----------------------------------------------------------------------------
// hpa_rgb_back
// Gain on saturation and value, HSV to RGB, channel scaling.
// ----------------------------------------------------------------------------
module hpa_rgb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld_i,
  input  hpa_pkg::hsv_t    hsv_i,
  input  hpa_pkg::cfg_t    cfg_i,
  output logic             vld_o,
  output hpa_pkg::pix_out_t pix_o
);
  import hpa_pkg::*;

  localparam int NS = 8;

  logic vld_r [NS];

  // stage e: gain products
  logic [24:0] esp_r, esp_nxt, evp_r, evp_nxt;
  logic        espos_r, espos_nxt, evpos_r, evpos_nxt;
  logic [14:0] eh_r;
  logic [7:0]  ea_r;
  // stage f: reciprocal products
  logic [49:0] fsm_r, fsm_nxt, fvm_r, fvm_nxt;
  logic        fspos_r, fvpos_r;
  logic [14:0] fh_r;
  logic [7:0]  fa_r;
  // stage g: clamped s, v and sector split
  logic [16:0] gs_r, gs_nxt, gv_r, gv_nxt;
  logic [2:0]  gi_r, gi_nxt;
  logic [11:0] gf_r, gf_nxt;
  logic [7:0]  ga_r;
  // stage h: partial products
  logic [28:0] hsf_r, hsf_nxt, hsf2_r, hsf2_nxt;
  logic [33:0] hpm_r, hpm_nxt;
  logic [16:0] hv_r;
  logic [2:0]  hi_r;
  logic [7:0]  ha_r;
  // stage i: v times remaining fraction
  logic [44:0] iqm_r, iqm_nxt, itm_r, itm_nxt;
  logic [16:0] ip_r, ip_nxt, iv_r;
  logic [2:0]  ii_r;
  logic [7:0]  ia_r;
  // stage j: divide by 15
  logic [40:0] jqr_r, jqr_nxt, jtr_r, jtr_nxt;
  logic [16:0] jp_r, jv_r;
  logic [2:0]  ji_r;
  logic [7:0]  ja_r;
  // stage k: channel select
  logic [16:0] kr_r, kr_nxt, kg_r, kg_nxt, kb_r, kb_nxt;
  logic [7:0]  ka_r;
  // stage l: output
  pix_out_t    pix_r, pix_nxt;

  // stage e
  always_comb begin
    logic signed [8:0] gsat, gval;
    gsat = $signed({cfg_i.saturation_percent[7], cfg_i.saturation_percent}) + 9'sd100;
    gval = $signed({cfg_i.value_percent[7], cfg_i.value_percent}) + 9'sd100;
    espos_nxt = (gsat > 9'sd0);
    evpos_nxt = (gval > 9'sd0);
    esp_nxt = 25'(hsv_i.sat) * 25'(gsat[7:0]);
    evp_nxt = 25'(hsv_i.val) * 25'(gval[7:0]);
  end

  // stage f
  assign fsm_nxt = 50'(esp_r) * 50'(RECIP_100);
  assign fvm_nxt = 50'(evp_r) * 50'(RECIP_100);

  // stage g
  always_comb begin
    logic [18:0] sq, vq;
    logic [14:0] sbase;
    sq = fsm_r[49:31];
    vq = fvm_r[49:31];
    gs_nxt = !fspos_r ? 17'd0 : (sq > 19'(ONE_Q16)) ? 17'(ONE_Q16) : sq[16:0];
    gv_nxt = !fvpos_r ? 17'd0 : (vq > 19'(ONE_Q16)) ? 17'(ONE_Q16) : vq[16:0];
    if (fh_r >= 15'(5 * SEXTANT)) begin
      gi_nxt = 3'd5; sbase = 15'(5 * SEXTANT);
    end else if (fh_r >= 15'(4 * SEXTANT)) begin
      gi_nxt = 3'd4; sbase = 15'(4 * SEXTANT);
    end else if (fh_r >= 15'(3 * SEXTANT)) begin
      gi_nxt = 3'd3; sbase = 15'(3 * SEXTANT);
    end else if (fh_r >= 15'(2 * SEXTANT)) begin
      gi_nxt = 3'd2; sbase = 15'(2 * SEXTANT);
    end else if (fh_r >= 15'(SEXTANT)) begin
      gi_nxt = 3'd1; sbase = 15'(SEXTANT);
    end else begin
      gi_nxt = 3'd0; sbase = 15'd0;
    end
    gf_nxt = 12'(fh_r - sbase);
  end

  // stage h
  assign hsf_nxt  = 29'(gs_r) * 29'(gf_r);
  assign hsf2_nxt = 29'(gs_r) * 29'(12'(SEXTANT) - gf_r);
  assign hpm_nxt  = 34'(gv_r) * 34'(17'(ONE_Q16) - gs_r);

  // stage i
  assign iqm_nxt = 45'(hv_r) * 45'(28'(SEXT_K) - hsf_r[27:0]);
  assign itm_nxt = 45'(hv_r) * 45'(28'(SEXT_K) - hsf2_r[27:0]);
  assign ip_nxt  = hpm_r[32:16];

  // stage j: product >> 24 then divide by 15
  assign jqr_nxt = 41'(iqm_r[43:24]) * 41'(RECIP_15);
  assign jtr_nxt = 41'(itm_r[43:24]) * 41'(RECIP_15);

  // stage k: sector select
  always_comb begin
    logic [16:0] q, t;
    q = jqr_r[40:24];
    t = jtr_r[40:24];
    case (ji_r)
      3'd0: begin kr_nxt = jv_r; kg_nxt = t;    kb_nxt = jp_r; end
      3'd1: begin kr_nxt = q;    kg_nxt = jv_r; kb_nxt = jp_r; end
      3'd2: begin kr_nxt = jp_r; kg_nxt = jv_r; kb_nxt = t;    end
      3'd3: begin kr_nxt = jp_r; kg_nxt = q;    kb_nxt = jv_r; end
      3'd4: begin kr_nxt = t;    kg_nxt = jp_r; kb_nxt = jv_r; end
      default: begin kr_nxt = jv_r; kg_nxt = jp_r; kb_nxt = q; end
    endcase
  end

  // stage l: scale to channel range and clamp
  function automatic logic [7:0] to_chan(input logic [16:0] x);
    logic [24:0] m;
    m = {x, 8'd0} - {8'd0, x};
    to_chan = (m[24:16] > 9'd255) ? 8'd255 : m[23:16];
  endfunction

  always_comb begin
    pix_nxt.red_out   = to_chan(kr_r);
    pix_nxt.green_out = to_chan(kg_r);
    pix_nxt.blue_out  = to_chan(kb_r);
    pix_nxt.alpha_out = ka_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      esp_r <= esp_nxt;   evp_r <= evp_nxt;
      espos_r <= espos_nxt; evpos_r <= evpos_nxt;
      eh_r <= hsv_i.hue;  ea_r <= hsv_i.alpha;
      fsm_r <= fsm_nxt;   fvm_r <= fvm_nxt;
      fspos_r <= espos_r; fvpos_r <= evpos_r;
      fh_r <= eh_r;       fa_r <= ea_r;
      gs_r <= gs_nxt;     gv_r <= gv_nxt;
      gi_r <= gi_nxt;     gf_r <= gf_nxt;   ga_r <= fa_r;
      hsf_r <= hsf_nxt;   hsf2_r <= hsf2_nxt; hpm_r <= hpm_nxt;
      hv_r <= gv_r;       hi_r <= gi_r;     ha_r <= ga_r;
      iqm_r <= iqm_nxt;   itm_r <= itm_nxt; ip_r <= ip_nxt;
      iv_r <= hv_r;       ii_r <= hi_r;     ia_r <= ha_r;
      jqr_r <= jqr_nxt;   jtr_r <= jtr_nxt; jp_r <= ip_r;
      jv_r <= iv_r;       ji_r <= ii_r;     ja_r <= ia_r;
      kr_r <= kr_nxt;     kg_r <= kg_nxt;   kb_r <= kb_nxt; ka_r <= ja_r;
      pix_r <= pix_nxt;
    end
  end

  assign vld_o = vld_r[NS-1];
  assign pix_o = pix_r;

endmodule

/* design/hsv_pixel_adjust.sv */
// ----------------------------------------------------------------------------
// hsv_pixel_adjust
// Hue, saturation and value adjustment of an RGBA pixel stream.
// ----------------------------------------------------------------------------
// usage:
//   in_data carries one RGBA pixel per transaction (in_valid / in_stall),
//   out_data the adjusted pixel (out_valid / out_stall). A transaction
//   completes on a clock edge with valid high and stall low.
//   cfg_we / cfg_idx / cfg_wdata write hue offset (0), saturation percent
//   (1) and value percent (2); write only while the pipeline is empty.
// throughput: one pixel per clock unless stalled; fully pipelined datapath.
// pipeline: input register, stage a, the two 5-stage restoring dividers (hue
//   and saturation) side by side, the HSV output register, then the multiply
//   chain of the HSV to RGB conversion in stages e to l.
// stall: the whole pipeline holds while out_valid and out_stall are both
//   high, bubbles included, and in_stall follows in the same cycle.
// reset: rst_n low clears all valid bits and the three registers to zero.
// ----------------------------------------------------------------------------
module hsv_pixel_adjust (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hpa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [8:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hpa_pkg::pix_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hpa_pkg::pix_out_t             out_data
);
  import hpa_pkg::*;

  cfg_t cfg_r;
  logic adv;
  logic mid_vld;
  hsv_t mid_hsv;

  // pipeline moves unless a result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HUE: cfg_r.hue_offset         <= $signed(cfg_wdata);
        CFG_SAT: cfg_r.saturation_percent <= $signed(cfg_wdata[7:0]);
        CFG_VAL: cfg_r.value_percent      <= $signed(cfg_wdata[7:0]);
        default: ;
      endcase
    end
  end

  // rgb to hsv
  hpa_hsv_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (in_valid),
    .pix_i (in_data),
    .cfg_i (cfg_r),
    .vld_o (mid_vld),
    .hsv_o (mid_hsv)
  );

  // gains and hsv to rgb
  hpa_rgb_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (mid_vld),
    .hsv_i (mid_hsv),
    .cfg_i (cfg_r),
    .vld_o (out_valid),
    .pix_o (out_data)
  );

  // a held result freezes the input side
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result held");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
